FILE: src/rmc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmc_pkg
// Shared constants for the range membership count unit: field widths,
// action codes, status codes and the default table depth.
// ---------------------------------------------------------------------------
`default_nettype none

package rmc_pkg;

   // payload widths
   localparam int unsigned BOUND_W  = 64;
   localparam int unsigned COUNT_W  = 64;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned HELD_W   = 9;

   // default number of table entries
   localparam int unsigned TABLE_DEPTH_DEFAULT = 256;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REVERSED = 2'd2;

endpackage

`default_nettype wire

FILE: src/rmc_bounds_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmc_bounds_ram
// Single write port, single read port memory holding the lower and upper
// bound of each stored range side by side. Read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module rmc_bounds_ram #(
   parameter int unsigned DEPTH = rmc_pkg::TABLE_DEPTH_DEFAULT,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [rmc_pkg::BOUND_W-1:0] wr_lower,
   input  wire logic [rmc_pkg::BOUND_W-1:0] wr_upper,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [rmc_pkg::BOUND_W-1:0] rd_lower,
   output logic      [rmc_pkg::BOUND_W-1:0] rd_upper
);

   localparam int unsigned W = rmc_pkg::BOUND_W;

   // upper bound in the high half, lower bound in the low half
   logic [2*W-1:0] mem [DEPTH];
   logic [2*W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_upper, wr_lower};
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_lower = rd_data_ff[W-1:0];
   assign rd_upper = rd_data_ff[2*W-1:W];

endmodule

`default_nettype wire

FILE: src/range_membership_count_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_membership_count_unit
// Table of inclusive identifier ranges with a saturating count of queries
// that fall inside any stored range.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start high and busy low. The
//   action selects clear (empty table, zero count), load (append one range)
//   or query (test query_id against every stored range). Action 3 does
//   nothing but still answers.
//   Every item gives exactly one result beat, shown for one cycle with
//   rsp_strobe high; the receiver cannot stall, so results are never held.
//   Clear, load and the unused action answer in the cycle after acceptance
//   and busy stays low, so such items can be taken every cycle.
//   A query walks the bounds memory one entry per cycle through its single
//   read port and stops at the first hit; an empty table answers without
//   any read. Busy is high until the result beat, in which the next item
//   may be taken.
//   A load is refused with status 1 when the table is full and with
//   status 2 when range_first exceeds range_last; the table is unchanged.
//   Reset empties the table and zeroes the count; the memory itself is not
//   cleared since only entries below the fill count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module range_membership_count_unit #(
   parameter int unsigned TABLE_DEPTH = rmc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rmc_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [rmc_pkg::BOUND_W-1:0]   req_range_first,
   input  wire logic [rmc_pkg::BOUND_W-1:0]   req_range_last,
   input  wire logic [rmc_pkg::BOUND_W-1:0]   req_query_id,
   output logic                               rsp_strobe,
   output logic      [rmc_pkg::STATUS_W-1:0]  rsp_status,
   output logic                               rsp_hit,
   output logic      [rmc_pkg::COUNT_W-1:0]   rsp_hits_so_far,
   output logic      [rmc_pkg::HELD_W-1:0]    rsp_ranges_held
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned HW = rmc_pkg::HELD_W;

   typedef enum logic {
      STATE_IDLE,
      STATE_SCAN
   } state_type;

   state_type                       state_ff,  state_in;
   logic [CW-1:0]                   count_ff,  count_in;
   logic [rmc_pkg::COUNT_W-1:0]     hits_ff,   hits_in;
   logic [AW-1:0]                   idx_ff,    idx_in;
   logic                            last_ff,   last_in;
   logic [rmc_pkg::BOUND_W-1:0]     id_ff,     id_in;
   logic                            strobe_ff, strobe_in;
   logic [rmc_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic                            hit_ff,    hit_in;

   logic                            wr_en;
   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;
   logic [rmc_pkg::BOUND_W-1:0]     rd_lower;
   logic [rmc_pkg::BOUND_W-1:0]     rd_upper;
   logic                            match;
   logic                            full;
   logic [CW+HW-1:0]                held_ext;

   // bounds memory
   rmc_bounds_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_bounds_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[AW-1:0]),
      .wr_lower (req_range_first),
      .wr_upper (req_range_last),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_lower (rd_lower),
      .rd_upper (rd_upper)
   );

   // compare of the entry read in the previous cycle
   assign match = (rd_lower <= id_ff) && (id_ff <= rd_upper);
   assign full  = (count_ff == CW'(TABLE_DEPTH));

   // next state
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      hits_in   = hits_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      id_in     = id_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      hit_in    = hit_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;

      unique case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               status_in = rmc_pkg::ST_OK;
               hit_in    = 1'b0;
               unique case (req_action)
                  rmc_pkg::ACT_CLEAR: begin
                     count_in  = '0;
                     hits_in   = '0;
                     strobe_in = 1'b1;
                  end
                  rmc_pkg::ACT_LOAD: begin
                     strobe_in = 1'b1;
                     priority if (full) begin
                        status_in = rmc_pkg::ST_FULL;
                     end else if (req_range_first > req_range_last) begin
                        status_in = rmc_pkg::ST_REVERSED;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  rmc_pkg::ACT_QUERY: begin
                     id_in = req_query_id;
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                     end else begin
                        // first read goes out with the accept
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = AW'(1);
                        last_in  = (count_ff == CW'(1));
                        state_in = STATE_SCAN;
                     end
                  end
                  rmc_pkg::ACT_UNUSED: begin
                     strobe_in = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         STATE_SCAN: begin
            priority if (match) begin
               hit_in    = 1'b1;
               hits_in   = (hits_ff == '1) ? hits_ff : hits_ff + 64'd1;
               strobe_in = 1'b1;
               state_in  = STATE_IDLE;
            end else if (last_ff) begin
               strobe_in = 1'b1;
               state_in  = STATE_IDLE;
            end else begin
               // fetch next entry
               rd_en   = 1'b1;
               rd_addr = idx_ff;
               idx_in  = idx_ff + AW'(1);
               last_in = (CW'(idx_ff) == count_ff - CW'(1));
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= STATE_IDLE;
         count_ff  <= '0;
         hits_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         hits_ff   <= hits_in;
         strobe_ff <= strobe_in;
      end
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      id_ff     <= id_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   // result beat
   assign held_ext        = (CW + HW)'(count_ff);
   assign busy            = (state_ff == STATE_SCAN);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_hits_so_far = hits_ff;
   assign rsp_ranges_held = held_ext[HW-1:0];

endmodule

`default_nettype wire

FILE: tb/tb_range_membership_count_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_range_membership_count_unit
// Self-checking bench for the range membership count unit. A short table of
// directed beats covers the bounds extremes, every action and the reversed
// bounds refusal. Random sequences follow: clear, a burst of loads and a run
// of queries aimed at and around the stored bounds, with noise mixed in. At
// least one sequence fills the table past its depth. Every answer beat is
// compared field by field against a typed answer or a behavioral model of
// the table, with random gaps on the sender side between beats.
// ---------------------------------------------------------------------------

module tb_range_membership_count_unit;

   localparam int unsigned BW          = rmc_pkg::BOUND_W;
   localparam int unsigned CNTW        = rmc_pkg::COUNT_W;
   localparam int unsigned ACTW        = rmc_pkg::ACTION_W;
   localparam int unsigned STW         = rmc_pkg::STATUS_W;
   localparam int unsigned HLDW        = rmc_pkg::HELD_W;
   localparam int unsigned DEPTH       = rmc_pkg::TABLE_DEPTH_DEFAULT;
   localparam int unsigned RAND_BEATS  = 1430;
   localparam int unsigned TAIL_CYCLES = DEPTH + 16;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam logic [BW-1:0] ALL1      = '1;
   localparam int unsigned DIR_ROWS    = 23;
   localparam int unsigned PEND_DEPTH  = 16;

   // value ranges used when picking bounds and identifiers
   typedef enum int unsigned {DOM_NARROW, DOM_WIDE, DOM_EDGE} value_dom_type;

   typedef struct packed {
      logic [STW-1:0]  status;
      logic            hit;
      logic [CNTW-1:0] hits;
      logic [HLDW-1:0] held;
   } answer_type;

   typedef struct packed {
      logic [ACTW-1:0] action;
      logic [BW-1:0]   first;
      logic [BW-1:0]   last;
      logic [BW-1:0]   id;
      logic            typed;
      answer_type      answer;
   } stim_row_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic [ACTW-1:0]     req_action      = rmc_pkg::ACT_CLEAR;
   logic [BW-1:0]       req_range_first = '0;
   logic [BW-1:0]       req_range_last  = '0;
   logic [BW-1:0]       req_query_id    = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [STW-1:0]      rsp_status;
   logic                rsp_hit;
   logic [CNTW-1:0]     rsp_hits_so_far;
   logic [HLDW-1:0]     rsp_ranges_held;

   // model of the range table
   logic [BW-1:0]       bound_lo [DEPTH];
   logic [BW-1:0]       bound_hi [DEPTH];
   int unsigned         range_fill = 0;
   logic [CNTW-1:0]     hit_tally  = '0;

   // expected answers in flight, kept as a ring
   answer_type          pend_buf [PEND_DEPTH];
   int unsigned         pend_wr    = 0;
   int unsigned         pend_rd    = 0;

   stim_row_type        dir_tab [DIR_ROWS];
   int unsigned         err_count  = 0;
   int unsigned         beats_sent = 0;
   int unsigned         cycles     = 0;
   bit                  no_idle    = 1'b0;

   range_membership_count_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .req_query_id    (req_query_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_hits_so_far (rsp_hits_so_far),
      .rsp_ranges_held (rsp_ranges_held)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // apply one accepted beat to the table model and return its answer
   function automatic answer_type table_step(input logic [ACTW-1:0] act,
                                             input logic [BW-1:0] first,
                                             input logic [BW-1:0] last,
                                             input logic [BW-1:0] id);
      answer_type ans;
      ans.status = rmc_pkg::ST_OK;
      ans.hit    = 1'b0;
      case (act)
         rmc_pkg::ACT_CLEAR: begin
            range_fill = 0;
            hit_tally  = '0;
         end
         rmc_pkg::ACT_LOAD: begin
            if (range_fill >= DEPTH) begin
               ans.status = rmc_pkg::ST_FULL;
            end else if (first > last) begin
               ans.status = rmc_pkg::ST_REVERSED;
            end else begin
               bound_lo[range_fill] = first;
               bound_hi[range_fill] = last;
               range_fill++;
            end
         end
         rmc_pkg::ACT_QUERY: begin
            for (int unsigned i = 0; i < range_fill; i++) begin
               if (bound_lo[i] <= id && id <= bound_hi[i]) ans.hit = 1'b1;
            end
            if (ans.hit && hit_tally != ALL1) hit_tally++;
         end
         default: begin
         end
      endcase
      ans.hits = hit_tally;
      ans.held = range_fill[HLDW-1:0];
      return ans;
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BW-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [BW-1:0] pick_value(input value_dom_type dom);
      case (dom)
         DOM_NARROW: return BW'($urandom_range(0, 2000));
         DOM_WIDE:   return rand64();
         default: begin
            if ($urandom_range(0, 1) == 0) return BW'($urandom_range(0, 300));
            return ALL1 - BW'($urandom_range(0, 300));
         end
      endcase
   endfunction

   // drive one beat, wait for the handshake, then record its answer
   task automatic issue_beat(input logic [ACTW-1:0] act,
                             input logic [BW-1:0] first,
                             input logic [BW-1:0] last,
                             input logic [BW-1:0] id,
                             input logic typed,
                             input answer_type typed_ans);
      answer_type  ans;
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_range_first <= first;
      req_range_last  <= last;
      req_query_id    <= id;
      @(posedge clock);
      while (busy) @(posedge clock);
      ans = table_step(act, first, last, id);
      pend_buf[pend_wr % PEND_DEPTH] = typed ? typed_ans : ans;
      pend_wr++;
      beats_sent++;
   endtask

   task automatic send(input logic [ACTW-1:0] act,
                       input logic [BW-1:0] first,
                       input logic [BW-1:0] last,
                       input logic [BW-1:0] id);
      issue_beat(act, first, last, id, 1'b0, '0);
   endtask

   // hold the sender off until every answer is back
   task automatic drain_answers();
      start <= 1'b0;
      do @(posedge clock); while (pend_rd != pend_wr);
   endtask

   // load one range: well formed or reversed on request
   task automatic load_range(input value_dom_type dom, input bit reversed);
      logic [BW-1:0] a;
      logic [BW-1:0] b;
      logic [BW-1:0] lo;
      logic [BW-1:0] hi;
      a = pick_value(dom);
      if (dom == DOM_WIDE) begin
         b = pick_value(dom);
      end else begin
         b = a + BW'($urandom_range(0, 150));
         if (b < a) b = ALL1;
      end
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (reversed) begin
         if (lo == hi) begin
            if (hi == ALL1) lo = hi - 1;
            else hi = lo + 1;
         end
         send(rmc_pkg::ACT_LOAD, hi, lo, rand64());
      end else begin
         send(rmc_pkg::ACT_LOAD, lo, hi, rand64());
      end
   endtask

   // query aimed at a stored bound or its neighbors, or anywhere
   task automatic query_id_near(input value_dom_type dom);
      logic [BW-1:0] id;
      int unsigned   idx;
      int unsigned   r;
      r = $urandom_range(0, 99);
      if (range_fill != 0 && r < 65) begin
         idx = $urandom_range(0, range_fill - 1);
         case ($urandom_range(0, 4))
            0: id = bound_lo[idx];
            1: id = bound_hi[idx];
            2: id = bound_lo[idx] - 1;
            3: id = bound_hi[idx] + 1;
            default: id = bound_lo[idx] + ((bound_hi[idx] - bound_lo[idx]) >> 1);
         endcase
      end else begin
         id = pick_value(dom);
      end
      send(rmc_pkg::ACT_QUERY, rand64(), rand64(), id);
   endtask

   // answer checker
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pend_rd == pend_wr) begin
            $error("answer beat with none outstanding");
            err_count++;
         end else begin
            want = pend_buf[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_status);
               err_count++;
            end
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d actual %0d", want.hit, rsp_hit);
               err_count++;
            end
            if (rsp_hits_so_far !== want.hits) begin
               $error("hits_so_far: expected %0d actual %0d", want.hits,
                      rsp_hits_so_far);
               err_count++;
            end
            if (rsp_ranges_held !== want.held) begin
               $error("ranges_held: expected %0d actual %0d", want.held,
                      rsp_ranges_held);
               err_count++;
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      value_dom_type dom;
      int unsigned   seq;
      int unsigned   n_load;
      int unsigned   n_query;
      int unsigned   r;
      bit            fill_up;

      // directed rows: typed answers where they follow at a glance
      dir_tab = '{
         // empty table, unused action, reversed bounds
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, ALL1, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd0}},
         '{rmc_pkg::ACT_UNUSED, ALL1, ALL1, ALL1, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd0}},
         '{rmc_pkg::ACT_LOAD,   64'd1, 64'd0, 64'd0, 1'b1,
           '{rmc_pkg::ST_REVERSED, 1'b0, 64'd0, 9'd0}},
         '{rmc_pkg::ACT_LOAD,   ALL1, 64'd0, ALL1, 1'b1,
           '{rmc_pkg::ST_REVERSED, 1'b0, 64'd0, 9'd0}},
         // single-point ranges at both extremes
         '{rmc_pkg::ACT_LOAD,   64'd0, 64'd0, ALL1, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd1}},
         '{rmc_pkg::ACT_LOAD,   ALL1, ALL1, 64'd0, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd2}},
         '{rmc_pkg::ACT_QUERY,  ALL1, 64'd0, 64'd0, 1'b1,
           '{rmc_pkg::ST_OK, 1'b1, 64'd1, 9'd2}},
         '{rmc_pkg::ACT_QUERY,  64'd0, ALL1, ALL1, 1'b1,
           '{rmc_pkg::ST_OK, 1'b1, 64'd2, 9'd2}},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, 64'd1, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd2, 9'd2}},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, ALL1 - 1, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd2, 9'd2}},
         // inclusive edges of an ordinary range
         '{rmc_pkg::ACT_LOAD,   64'd100, 64'd200, 64'h0, 1'b0, '0},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, 64'd100, 1'b0, '0},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, 64'd200, 1'b0, '0},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, 64'd99, 1'b0, '0},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, 64'd201, 1'b0, '0},
         '{rmc_pkg::ACT_LOAD,   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                64'hFFFF_0000_FFFF_0000, 1'b0, '0},
         '{rmc_pkg::ACT_QUERY,  64'h5555_5555_5555_5555, 64'h0,
                                64'h8000_0000_0000_0000, 1'b0, '0},
         '{rmc_pkg::ACT_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                                64'd150, 1'b0, '0},
         // clear with junk in unused fields, then one full-span range
         '{rmc_pkg::ACT_CLEAR,  ALL1, ALL1, ALL1, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd0}},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, 64'd0, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd0}},
         '{rmc_pkg::ACT_LOAD,   64'd0, ALL1, 64'd5, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd1}},
         '{rmc_pkg::ACT_QUERY,  64'd0, 64'd0, 64'h1234_5678_9ABC_DEF0, 1'b1,
           '{rmc_pkg::ST_OK, 1'b1, 64'd1, 9'd1}},
         '{rmc_pkg::ACT_CLEAR,  64'd0, 64'd0, 64'd0, 1'b1,
           '{rmc_pkg::ST_OK, 1'b0, 64'd0, 9'd0}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned i = 0; i < DIR_ROWS; i++) begin
         issue_beat(dir_tab[i].action, dir_tab[i].first, dir_tab[i].last,
                    dir_tab[i].id, dir_tab[i].typed, dir_tab[i].answer);
      end

      // random sequences: clear, loads, queries, with noise
      seq = 0;
      while (beats_sent < DIR_ROWS + RAND_BEATS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         dom     = value_dom_type'($urandom_range(0, 2));
         fill_up = (seq == 3) || ($urandom_range(0, 149) == 0);

         if (seq == 2 || $urandom_range(0, 9) == 0) drain_answers();

         if (fill_up || $urandom_range(0, 99) < 80) begin
            send(rmc_pkg::ACT_CLEAR, rand64(), rand64(), rand64());
         end

         n_load  = fill_up ? DEPTH + $urandom_range(2, 5) : $urandom_range(0, 12);
         n_query = fill_up ? 6 : $urandom_range(2, 16);

         for (int unsigned k = 0; k < n_load; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8) load_range(dom, 1'b1);
            else if (r < 12) send(rmc_pkg::ACT_UNUSED, rand64(), rand64(), rand64());
            else load_range(dom, 1'b0);
         end

         for (int unsigned k = 0; k < n_query; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6) send(rmc_pkg::ACT_UNUSED, rand64(), rand64(), rand64());
            else if (r < 9) send(rmc_pkg::ACT_CLEAR, rand64(), rand64(), rand64());
            else if (r < 14) load_range(DOM_WIDE, $urandom_range(0, 1));
            else query_id_near(dom);
         end
         seq++;
      end

      // wrap up
      drain_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/rmc_pkg.sv
src/rmc_bounds_ram.sv
src/range_membership_count_unit.sv
tb/tb_range_membership_count_unit.sv
